// ===== src/abpw_pkg.sv =====
// Package for the alpha-blend pixel writer: store geometry, codes and the
// payload and control structs shared by the controller, datapath and top level.
package abpw_pkg;

   localparam int STORE_BYTES = 1048576;
   localparam int LANES       = 4;
   localparam int LANE_BITS   = $clog2(LANES);
   localparam int STORE_WORDS = STORE_BYTES / LANES;
   localparam int WORD_AW     = $clog2(STORE_WORDS);
   localparam int PIX_BYTES   = 3;
   localparam int OFF_W       = 29;
   localparam int CSR_AW      = 2;
   localparam int CSR_DW      = 15;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [1:0] {
      WS_WRITTEN = 2'd0,
      WS_OUTSIDE = 2'd1,
      WS_BEYOND  = 2'd2
   } write_status_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_HRES   = 2'd0,
      CSR_VRES   = 2'd1,
      CSR_FORMAT = 2'd2,
      CSR_PITCH  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_OFF,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [15:0] x_coord;
      logic [15:0] y_coord;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [7:0]  alpha_in;
   } req_payload_type;

   typedef struct packed {
      write_status_type write_status;
      logic [19:0]      byte_offset;
      logic [7:0]       red_out;
      logic [7:0]       green_out;
      logic [7:0]       blue_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [12:0] hres;
      logic [12:0] vres;
      logic        fmt;
      logic [14:0] pitch;
   } csr_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic mul;
      logic offs;
      logic read;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_busy;
   } dp_status_type;

endpackage

// ===== src/abpw_ctrl.sv =====
// Sequencer for the pixel writer: store clear sweep, then one pixel at a time
// through multiply, offset, bank read and blend/write steps. Uses abpw_pkg.
module abpw_ctrl
   import abpw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_OFF;
         ST_OFF:   state_in = ST_READ;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MUL:   cmd.mul    = 1'b1;
         ST_OFF:   cmd.offs   = 1'b1;
         ST_READ:  cmd.read   = 1'b1;
         ST_WRITE: cmd.commit = !status.out_busy;
         default:  cmd        = '0;
      endcase
   end

   // reset always lands in the clear sweep
   a_reset_clear: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("not in clear sweep after reset");

   // sweep runs until the last word is cleared
   a_clear_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR && !status.clear_last |=> state_ff == ST_CLEAR)
      else $error("clear sweep left early");

   // a committed pixel frees the sequencer for the next beat
   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == ST_IDLE && !req_stall)
      else $error("sequencer not idle after commit");

endmodule

// ===== src/abpw_dp.sv =====
// Datapath for the pixel writer: offset arithmetic, four byte-lane banks of the
// frame store, channel blend and the result register. Uses abpw_pkg.
module abpw_dp
   import abpw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  csr_type         csr,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   status,
   input  req_payload_type req_payload,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam logic [OFF_W-1:0]   STORE_LIMIT = OFF_W'(STORE_BYTES);
   localparam logic [WORD_AW-1:0] LAST_WORD   = WORD_AW'(STORE_WORDS - 1);

   req_payload_type req_ff;
   logic [27:0]        prod_ff;
   logic [14:0]        xb_ff;
   logic               outside_ff;
   logic [OFF_W-1:0]   off_ff;
   logic               beyond_ff;
   logic [WORD_AW-1:0] clear_idx_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   logic [12:0]        x13;
   logic [12:0]        y13;
   logic [OFF_W-1:0]   off_sum;
   logic               drop;
   logic [OFF_W-1:0]   addr_k   [PIX_BYTES];
   logic [7:0]         new_byte [PIX_BYTES];
   logic [7:0]         old_byte [PIX_BYTES];
   logic [7:0]         out_byte [PIX_BYTES];
   logic [LANES-1:0]   lane_used;
   logic [WORD_AW-1:0] lane_addr [LANES];
   logic [7:0]         lane_byte [LANES];
   logic [LANES-1:0][7:0] rd_data;

   function automatic logic [7:0] mix_channel(input logic [7:0] old_v,
                                              input logic [7:0] new_v,
                                              input logic [7:0] a);
      logic [16:0] p_old;
      logic [15:0] p_new;
      logic [8:0]  s;
      p_old = {9'd0, old_v} * ({9'd0, 8'd0} + (17'd256 - {9'd0, a}));
      p_new = {8'd0, new_v} * {8'd0, a};
      s     = p_old[16:8] + {1'b0, p_new[15:8]};
      return s[7:0];
   endfunction

   assign x13 = req_ff.x_coord[12:0];
   assign y13 = req_ff.y_coord[12:0];

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
      if (cmd.mul) begin
         prod_ff    <= {15'd0, y13} * {13'd0, csr.pitch};
         xb_ff      <= csr.fmt ? {x13, 2'b00} : ({2'b00, x13} + {1'b0, x13, 1'b0});
         outside_ff <= (req_ff.x_coord >= {3'b000, csr.hres}) ||
                       (req_ff.y_coord >= {3'b000, csr.vres});
      end
      if (cmd.offs) begin
         off_ff    <= off_sum;
         beyond_ff <= (off_sum + OFF_W'(2)) >= STORE_LIMIT;
      end
   end

   assign off_sum = OFF_W'(prod_ff) + OFF_W'(xb_ff);
   assign drop    = outside_ff || beyond_ff;

   assign new_byte[0] = req_ff.blue_in;
   assign new_byte[1] = req_ff.green_in;
   assign new_byte[2] = req_ff.red_in;

   // byte k of the pixel lives in lane (off+k)[1:0]; three consecutive bytes never share a lane
   always_comb begin
      for (int k = 0; k < PIX_BYTES; k++) begin
         addr_k[k]   = off_ff + OFF_W'(k);
         old_byte[k] = rd_data[addr_k[k][LANE_BITS-1:0]];
         out_byte[k] = (req_ff.alpha_in == ALPHA_OPAQUE) ? new_byte[k] :
                       mix_channel(old_byte[k], new_byte[k], req_ff.alpha_in);
      end
      for (int l = 0; l < LANES; l++) begin
         lane_used[l] = 1'b0;
         lane_addr[l] = addr_k[0][WORD_AW+LANE_BITS-1:LANE_BITS];
         lane_byte[l] = '0;
         for (int k = 0; k < PIX_BYTES; k++) begin
            if (addr_k[k][LANE_BITS-1:0] == LANE_BITS'(l)) begin
               lane_used[l] = 1'b1;
               lane_addr[l] = addr_k[k][WORD_AW+LANE_BITS-1:LANE_BITS];
               lane_byte[l] = out_byte[k];
            end
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [7:0] bank_ff [STORE_WORDS];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (cmd.clear) begin
            bank_ff[clear_idx_ff] <= '0;
         end else if (cmd.commit && !drop && lane_used[l]) begin
            bank_ff[lane_addr[l]] <= lane_byte[l];
         end
         if (cmd.read) rd_ff <= bank_ff[lane_addr[l]];
      end

      assign rd_data[l] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear) begin
         clear_idx_ff <= clear_idx_ff + WORD_AW'(1);
      end
   end

   // result register: holds one beat so the next pixel can be taken meanwhile
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (outside_ff) begin
            rsp_ff <= '{WS_OUTSIDE, 20'd0, 8'd0, 8'd0, 8'd0};
         end else if (beyond_ff) begin
            rsp_ff <= '{WS_BEYOND, 20'd0, 8'd0, 8'd0, 8'd0};
         end else begin
            rsp_ff <= '{WS_WRITTEN, off_ff[19:0], out_byte[2], out_byte[1], out_byte[0]};
         end
      end
   end

   assign status.clear_last = (clear_idx_ff == LAST_WORD);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_status != WS_WRITTEN |->
         rsp_ff.byte_offset == '0 && rsp_ff.red_out == '0 &&
         rsp_ff.green_out == '0 && rsp_ff.blue_out == '0)
      else $error("dropped pixel carries payload");

   a_write_status: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !drop |=> rsp_valid_ff && rsp_ff.write_status == WS_WRITTEN)
      else $error("written pixel reported as dropped");

   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !cmd.commit && !cmd.read)
      else $error("pixel access during clear sweep");

endmodule

// ===== src/alpha_blend_pixel_writer_unit.sv =====
// Alpha-blend pixel writer, top level: configuration registers, sequencer and
// datapath. Depends on abpw_pkg, abpw_ctrl and abpw_dp.
//
// Usage:
//   req_* carries one pixel write per beat (x, y, colour, alpha); a beat is
//   taken when req_valid is high and req_stall is low. rsp_* returns one
//   result per pixel: status, blue byte offset and the colour stored.
//   csr_* writes the resolution, pixel format and row pitch; write only
//   while no pixel is in flight.
// Sequence:
//   Each accepted pixel steps through multiply, offset add, frame store bank
//   read, then blend and write, and rsp_valid rises once it is written. The
//   sequencer handles one pixel at a time, so the read of one pixel always
//   sees the write of the one before.
// Reset:
//   Registers return to 1024 x 768, 4 bytes per pixel, pitch 4096. The frame
//   store is then zeroed by a sweep over all STORE_BYTES/4 words (262144),
//   one word of all four byte lanes per cycle; req_stall stays high meanwhile.
// Stall:
//   A result held by rsp_stall sits in the output register; the next pixel
//   is still taken and worked up to its write, where it waits for the slot.
module alpha_blend_pixel_writer_unit
   import abpw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_data
);

   csr_type       csr_ff;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.hres  <= 13'd1024;
         csr_ff.vres  <= 13'd768;
         csr_ff.fmt   <= 1'b1;
         csr_ff.pitch <= 15'd4096;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_HRES:   csr_ff.hres  <= csr_data[12:0];
            CSR_VRES:   csr_ff.vres  <= csr_data[12:0];
            CSR_FORMAT: csr_ff.fmt   <= csr_data[0];
            CSR_PITCH:  csr_ff.pitch <= csr_data;
         endcase
      end
   end

   abpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   abpw_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/tb_alpha_blend_pixel_writer_unit.sv =====
// Testbench for alpha_blend_pixel_writer_unit: drives pixel writes and register
// settings and checks every result beat against a blending model with its own
// shadow frame store. Depends on abpw_pkg and the block itself.
`timescale 1ns / 1ps

module tb_alpha_blend_pixel_writer_unit;
   import abpw_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int LONG_HOLD   = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_payload_type   req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_payload_type   rsp_payload;
   logic              csr_wr_en = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   alpha_blend_pixel_writer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // shadow of the frame store and the register file
   bit [7:0]    frame_shadow [STORE_BYTES];
   logic [12:0] cfg_hres  = 13'd1024;
   logic [12:0] cfg_vres  = 13'd768;
   logic        cfg_fmt   = 1'b1;
   logic [14:0] cfg_pitch = 15'd4096;

   rsp_payload_type expected_results [$];

   bit          idle_on = 1'b1;
   bit          long_hold_req = 1'b0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned settings_used = 1;
   int unsigned n_written = 0;
   int unsigned n_blended = 0;
   int unsigned n_outside = 0;
   int unsigned n_beyond = 0;

   function automatic logic [7:0] weigh_channel(input int unsigned old_v, new_v, alpha);
      int unsigned sum;
      sum = ((old_v * (256 - alpha)) >> 8) + ((new_v * alpha) >> 8);
      return sum[7:0];
   endfunction

   // Works out one pixel write against the shadow store and updates it.
   function automatic rsp_payload_type apply_pixel(input req_payload_type px);
      rsp_payload_type   res;
      longint unsigned   off;
      logic [7:0]        r, g, b;
      res = '0;
      res.write_status = WS_WRITTEN;
      if (px.x_coord >= cfg_hres || px.y_coord >= cfg_vres) begin
         res.write_status = WS_OUTSIDE;
         n_outside++;
         return res;
      end
      off = (cfg_fmt ? 64'd4 : 64'd3) * 64'(px.x_coord) + 64'(px.y_coord) * 64'(cfg_pitch);
      if (off + 64'd2 >= 64'(STORE_BYTES)) begin
         res.write_status = WS_BEYOND;
         n_beyond++;
         return res;
      end
      r = px.red_in;
      g = px.green_in;
      b = px.blue_in;
      if (px.alpha_in != ALPHA_OPAQUE) begin
         r = weigh_channel(frame_shadow[off + 2], px.red_in, px.alpha_in);
         g = weigh_channel(frame_shadow[off + 1], px.green_in, px.alpha_in);
         b = weigh_channel(frame_shadow[off], px.blue_in, px.alpha_in);
         n_blended++;
      end
      frame_shadow[off + 2] = r;
      frame_shadow[off + 1] = g;
      frame_shadow[off]     = b;
      n_written++;
      res.byte_offset = off[19:0];
      res.red_out     = r;
      res.green_out   = g;
      res.blue_out    = b;
      return res;
   endfunction

   function automatic req_payload_type pixel(input int unsigned x, y, r, g, b, a);
      req_payload_type px;
      px.x_coord  = x[15:0];
      px.y_coord  = y[15:0];
      px.red_in   = r[7:0];
      px.green_in = g[7:0];
      px.blue_in  = b[7:0];
      px.alpha_in = a[7:0];
      return px;
   endfunction

   // Mostly a small hot region so blends see earlier writes; the rest probes
   // the resolution edges, the end of the store and the full coordinate range.
   function automatic req_payload_type random_pixel();
      req_payload_type px;
      int unsigned     pick, bpp, xmax, ymax;
      bpp = cfg_fmt ? 4 : 3;
      px = pixel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      case ($urandom_range(0, 5))
         0: px.alpha_in = 8'd0;
         1: px.alpha_in = ALPHA_OPAQUE;
         2: px.alpha_in = $urandom_range(0, 1) ? 8'd254 : 8'd1;
         default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 6 && cfg_hres != 0 && cfg_vres != 0) begin
         xmax = (cfg_hres > 8) ? 7 : cfg_hres - 1;
         ymax = (cfg_vres > 4) ? 3 : cfg_vres - 1;
         px.x_coord = $urandom_range(0, xmax);
         px.y_coord = $urandom_range(0, ymax);
      end else if (pick < 7) begin
         px.x_coord = (cfg_hres == 0) ? 16'($urandom_range(0, 1))
                                      : 16'(cfg_hres - 1 + $urandom_range(0, 1));
         px.y_coord = (cfg_vres == 0 || $urandom_range(0, 1)) ? 16'($urandom_range(0, 1))
                                      : 16'(cfg_vres - 1 + $urandom_range(0, 1));
      end else if (pick < 8 && cfg_pitch != 0) begin
         px.y_coord = 16'(STORE_BYTES / cfg_pitch - $urandom_range(0, 1));
         px.x_coord = 16'($urandom_range(0, cfg_pitch / bpp + 1));
      end
      return px;
   endfunction

   // Returns at the rising edge where the beat was taken; valid stays up so
   // back-to-back beats need no toggle.
   task automatic send_pixel(input req_payload_type px);
      int unsigned gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= px;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(apply_pixel(px));
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_HRES:   cfg_hres  = value[12:0];
         CSR_VRES:   cfg_vres  = value[12:0];
         CSR_FORMAT: cfg_fmt   = value[0];
         CSR_PITCH:  cfg_pitch = value[14:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [CSR_DW-1:0] hres, vres, fmt, pitch);
      drain_results();
      write_csr(CSR_HRES, hres);
      write_csr(CSR_VRES, vres);
      write_csr(CSR_FORMAT, fmt);
      write_csr(CSR_PITCH, pitch);
      settings_used++;
   endtask

   task automatic run_phase(input logic [CSR_DW-1:0] hres, vres, fmt, pitch,
                            input int n_items);
      set_geometry(hres, vres, fmt, pitch);
      repeat (n_items) send_pixel(random_pixel());
   endtask

   // Reset geometry 1024 x 768, 4 bytes, pitch 4096: copy, blends, edges.
   task automatic test_directed();
      send_pixel(pixel(0, 0, 8'hFF, 8'h80, 8'h01, 8'hFF));
      send_pixel(pixel(0, 0, 8'h00, 8'hFF, 8'h7F, 8'd128));
      send_pixel(pixel(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'd0));
      send_pixel(pixel(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'd1));
      send_pixel(pixel(0, 0, 8'h00, 8'h00, 8'h00, 8'd254));
      send_pixel(pixel(1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(pixel(1, 0, 8'hFF, 8'hFF, 8'hFF, 8'd200));
      send_pixel(pixel(1023, 0, 8'h12, 8'h34, 8'h56, 8'hFF));
      send_pixel(pixel(1024, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(pixel(0, 768, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(pixel(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(pixel(1023, 255, 8'hAA, 8'h55, 8'hC3, 8'hFF)); // last pixel in the store
      send_pixel(pixel(1023, 255, 8'h00, 8'hFF, 8'h00, 8'd77));
      send_pixel(pixel(0, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));    // first row past the store
      send_pixel(pixel(1023, 767, 8'hFF, 8'hFF, 8'hFF, 8'd3));
      send_pixel(pixel(0, 0, 8'h00, 8'h00, 8'h00, 8'hFF));
   endtask

   task automatic test_geometry_extremes();
      // 3-byte pixels, pitch 16383: x 20 of row 64 ends one byte short of the top
      set_geometry(4096, 4096, 0, 16383);
      send_pixel(pixel(20, 64, 8'h11, 8'h22, 8'h33, 8'hFF));
      send_pixel(pixel(21, 64, 8'h11, 8'h22, 8'h33, 8'hFF));
      send_pixel(pixel(4095, 0, 8'h44, 8'h55, 8'h66, 8'd90));
      send_pixel(pixel(4096, 0, 8'h44, 8'h55, 8'h66, 8'd90));
      repeat (10) send_pixel(random_pixel());
      run_phase(0, 768, 1, 4096, 10);      // zero width drops all
      run_phase(1024, 0, 1, 4096, 10);     // zero height drops all
      // all ones: registers keep only their low bits, format bit ends up 0
      run_phase(15'h7FFF, 15'h7FFF, 15'h7FFE, 15'h7FFF, 16);
      run_phase(16, 4096, 0, 0, 16);       // zero pitch: every row aliases row 0
      run_phase(1, 1, 1, 16384, 8);
   endtask

   task automatic test_random_geometry();
      int unsigned hres, vres, fmt, pitch;
      for (int phase = 0; phase < 9; phase++) begin
         if ($urandom_range(0, 2) == 0) begin
            hres = $urandom_range(0, 8191);
            vres = $urandom_range(0, 8191);
         end else begin
            hres = $urandom_range(1, 64);
            vres = $urandom_range(1, 64);
         end
         fmt = $urandom_range(0, 1);
         case ($urandom_range(0, 2))
            0: pitch = hres * (fmt ? 4 : 3);
            1: pitch = $urandom_range(0, 32767);
            default: pitch = $urandom_range(0, 512);
         endcase
         run_phase(hres, vres, fmt, pitch, 150);
      end
   endtask

   // Receiver holds off long enough for the block to back up into req_stall.
   task automatic test_output_backpressure();
      set_geometry(1024, 768, 1, 4096);
      long_hold_req = 1'b1;
      repeat (24) send_pixel(random_pixel());
   endtask

   task automatic test_streaming();
      drain_results();
      idle_on = 1'b0;
      repeat (80) send_pixel(random_pixel());
   endtask

   always begin
      @(negedge clock);
      if (long_hold_req) begin
         rsp_stall <= 1'b1;
         repeat (LONG_HOLD) @(negedge clock);
         rsp_stall <= 1'b0;
         long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [19:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no pixel outstanding: %h", rsp_payload);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("write_status", want.write_status, rsp_payload.write_status);
            check_field("byte_offset", want.byte_offset, rsp_payload.byte_offset);
            check_field("red_out", want.red_out, rsp_payload.red_out);
            check_field("green_out", want.green_out, rsp_payload.green_out);
            check_field("blue_out", want.blue_out, rsp_payload.blue_out);
            beats_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      // the first beat waits out the store clear
      test_directed();
      test_geometry_extremes();
      test_random_geometry();
      test_output_backpressure();
      test_streaming();
      drain_results();
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         fail_count++;
      end
      $display("covered %0d pixel beats over %0d geometries, %0d result beats checked",
               items_sent, settings_used, beats_checked);
      $display("  %0d written (%0d blended), %0d outside resolution, %0d past the store",
               n_written, n_blended, n_outside, n_beyond);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
